@@ src/pidmd_pkg.sv @@
// Shared types, widths and codes for the PID motor drive with encoder count.
package pidmd_pkg;

  localparam int POSITION_WIDTH_DEF     = 24;
  localparam int GAIN_FRACTION_BITS_DEF = 8;
  localparam int COUNTS_PER_REV_DEF     = 400;

  localparam int DEG_PER_REV = 360;
  localparam int DRIVE_LIMIT = 255;

  localparam int SETPOINT_W = 16;
  localparam int GAIN_W     = 24;
  localparam int ERR_W      = 26;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int SUM_W      = 32;
  localparam int REPORT_W   = 24;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RESET = GAIN_W'(71680);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 2'd0,
    REG_PROP_GAIN  = 2'd1,
    REG_INTEG_GAIN = 2'd2,
    REG_DERIV_GAIN = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_ENCODER = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
    logic [REPORT_W-1:0]      report;
  } err_stage_t;

endpackage

@@ src/pidmd_pos_track.sv @@
// Encoder position counter that also tracks position*360/COUNTS_PER_REV as quotient and remainder.
module pidmd_pos_track #(
  parameter int POSITION_WIDTH = pidmd_pkg::POSITION_WIDTH_DEF,
  parameter int COUNTS_PER_REV = pidmd_pkg::COUNTS_PER_REV_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_en_i,
  input  logic                             step_up_i,
  output logic [POSITION_WIDTH-1:0]        position_o,
  output logic signed [POSITION_WIDTH+7:0] degrees_o
);
  import pidmd_pkg::*;

  localparam int QW = POSITION_WIDTH + 8;
  localparam int RW = $clog2(COUNTS_PER_REV) + 1;
  localparam int STEP_Q = DEG_PER_REV / COUNTS_PER_REV;
  localparam int STEP_R = DEG_PER_REV % COUNTS_PER_REV;

  // Quotient and remainder for the most negative and most positive positions,
  // loaded when the counter wraps.
  localparam longint HALF    = longint'(1) << (POSITION_WIDTH - 1);
  localparam longint CPR_L   = longint'(COUNTS_PER_REV);
  localparam longint MIN_MAG = HALF * DEG_PER_REV;
  localparam longint MIN_Q   = -((MIN_MAG + CPR_L - 1) / CPR_L);
  localparam longint MIN_R   = -MIN_MAG - MIN_Q * CPR_L;
  localparam longint MAX_MAG = (HALF - 1) * DEG_PER_REV;
  localparam longint MAX_Q   = MAX_MAG / CPR_L;
  localparam longint MAX_R   = MAX_MAG % CPR_L;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
  localparam logic [POSITION_WIDTH-1:0] POS_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};
  localparam logic signed [RW:0] CPR_S    = (RW+1)'(COUNTS_PER_REV);
  localparam logic signed [RW:0] STEP_R_S = (RW+1)'(STEP_R);

  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic signed [QW-1:0]      quo_q, quo_d;
  logic [RW-1:0]             rem_q, rem_d;
  logic signed [RW:0]        rem_up, rem_dn;

  assign rem_up = $signed({1'b0, rem_q}) + STEP_R_S;
  assign rem_dn = $signed({1'b0, rem_q}) - STEP_R_S;

  // Invariant: position*360 = quo*COUNTS_PER_REV + rem, with 0 <= rem < COUNTS_PER_REV.
  always_comb begin
    pos_d = pos_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (step_en_i) begin
      if (step_up_i) begin
        pos_d = pos_q + 1'b1;
        if (pos_q == POS_MAX) begin
          quo_d = QW'(MIN_Q);
          rem_d = RW'(MIN_R);
        end else if (rem_up >= CPR_S) begin
          quo_d = quo_q + QW'(STEP_Q + 1);
          rem_d = RW'(rem_up - CPR_S);
        end else begin
          quo_d = quo_q + QW'(STEP_Q);
          rem_d = RW'(rem_up);
        end
      end else begin
        pos_d = pos_q - 1'b1;
        if (pos_q == POS_MIN) begin
          quo_d = QW'(MAX_Q);
          rem_d = RW'(MAX_R);
        end else if (rem_dn < 0) begin
          quo_d = quo_q - QW'(STEP_Q + 1);
          rem_d = RW'(rem_dn + CPR_S);
        end else begin
          quo_d = quo_q - QW'(STEP_Q);
          rem_d = RW'(rem_dn);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
    end else begin
      pos_q <= pos_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign position_o = pos_q;
  // The quotient is a floor; a negative value with a remainder moves up by one
  // to truncate toward zero.
  assign degrees_o  = (quo_q[QW-1] && (rem_q != '0)) ? quo_q + QW'(1) : quo_q;

endmodule

@@ src/pidmd_err_path.sv @@
// Error saturation stage and the error-sum / previous-error update stage.
module pidmd_err_path #(
  parameter int POSITION_WIDTH = pidmd_pkg::POSITION_WIDTH_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  output logic                                        ready_o,
  input  logic signed [POSITION_WIDTH+7:0]            degrees_i,
  input  logic [pidmd_pkg::REPORT_W-1:0]              report_i,
  input  logic signed [pidmd_pkg::SETPOINT_W-1:0]     setpoint_i,
  output logic                                        valid_o,
  input  logic                                        ready_i,
  output pidmd_pkg::err_stage_t                       res_o
);
  import pidmd_pkg::*;

  localparam int QW = POSITION_WIDTH + 8;
  localparam int CW = (QW + 1 > ERR_W + 1) ? QW + 1 : ERR_W + 1;
  localparam logic signed [CW-1:0] ERR_HI = CW'((longint'(1) << (ERR_W - 1)) - 1);
  localparam logic signed [CW-1:0] ERR_LO = CW'(-(longint'(1) << (ERR_W - 1)));
  localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [CW-1:0]     err_full;
  logic signed [ERR_W-1:0]  err_sat;
  logic                     v2_q, v3_q;
  logic signed [ERR_W-1:0]  e2_q;
  logic [REPORT_W-1:0]      rep2_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [ERR_W-1:0]  prev_q;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [DIFF_W-1:0] diff;
  err_stage_t               res_q;
  logic                     ready2, ready3;

  assign err_full = CW'(setpoint_i) - CW'(degrees_i);

  always_comb begin
    if (err_full > ERR_HI) begin
      err_sat = ERR_W'(ERR_HI);
    end else if (err_full < ERR_LO) begin
      err_sat = ERR_W'(ERR_LO);
    end else begin
      err_sat = ERR_W'(err_full);
    end
  end

  assign sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(e2_q);

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_d = sum_wide[SUM_W] ? SUM_LO : SUM_HI;
    end else begin
      sum_d = SUM_W'(sum_wide);
    end
  end

  assign diff   = DIFF_W'(e2_q) - DIFF_W'(prev_q);
  assign ready3 = !v3_q || ready_i;
  assign ready2 = !v2_q || ready3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      sum_q  <= '0;
      prev_q <= '0;
    end else begin
      if (ready2) begin
        v2_q <= valid_i;
      end
      if (ready3) begin
        v3_q <= v2_q;
        if (v2_q) begin
          sum_q  <= sum_d;
          prev_q <= e2_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && valid_i) begin
      e2_q   <= err_sat;
      rep2_q <= report_i;
    end
    if (ready3 && v2_q) begin
      res_q.err    <= e2_q;
      res_q.diff   <= diff;
      res_q.sum    <= sum_d;
      res_q.report <= rep2_q;
    end
  end

  assign ready_o = ready2;
  assign valid_o = v3_q;
  assign res_o   = res_q;

endmodule

@@ src/pidmd_drive_calc.sv @@
// Gain multiplies, product sum, fraction shift and clamp into the result register.
module pidmd_drive_calc #(
  parameter int GAIN_FRACTION_BITS = pidmd_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  pidmd_pkg::err_stage_t            res_i,
  input  pidmd_pkg::gains_t                gains_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             direction_o,
  output logic [pidmd_pkg::DUTY_W-1:0]     duty_o,
  output logic [pidmd_pkg::REPORT_W-1:0]   position_report_o
);
  import pidmd_pkg::*;

  localparam int PP_W  = GAIN_W + ERR_W;
  localparam int PD_W  = GAIN_W + DIFF_W;
  localparam int PI_W  = GAIN_W + SUM_W;
  localparam int ACC_W = PI_W + 2;
  localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'((longint'(1) << GAIN_FRACTION_BITS) - 1);
  localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(DRIVE_LIMIT);
  localparam logic signed [ACC_W-1:0] LIM_LO = ACC_W'(-DRIVE_LIMIT);

  logic                    v4_q, v5_q, v6_q;
  logic                    ready4, ready5, ready6;
  logic signed [PP_W-1:0]  pp_d, pp_q;
  logic signed [PD_W-1:0]  pd_d, pd_q;
  logic signed [PI_W-1:0]  pi_d, pi_q;
  logic [REPORT_W-1:0]     rep4_q, rep5_q, rep6_q;
  logic signed [ACC_W-1:0] acc_d, acc_q;
  logic signed [ACC_W-1:0] biased, shifted;
  logic                    dir_d, dir_q;
  logic [DUTY_W-1:0]       duty_d, duty_q;

  assign pp_d = PP_W'($signed(gains_i.kp)) * PP_W'($signed(res_i.err));
  assign pd_d = PD_W'($signed(gains_i.kd)) * PD_W'($signed(res_i.diff));
  assign pi_d = PI_W'($signed(gains_i.ki)) * PI_W'($signed(res_i.sum));

  assign acc_d = ACC_W'(pp_q) + ACC_W'(pd_q) + ACC_W'(pi_q);

  // Bias negative sums so the arithmetic shift truncates toward zero.
  assign biased  = acc_q[ACC_W-1] ? acc_q + BIAS : acc_q;
  assign shifted = biased >>> GAIN_FRACTION_BITS;

  always_comb begin
    if (shifted > LIM_HI) begin
      dir_d  = 1'b1;
      duty_d = DUTY_W'(DRIVE_LIMIT);
    end else if (shifted < LIM_LO) begin
      dir_d  = 1'b0;
      duty_d = DUTY_W'(DRIVE_LIMIT);
    end else begin
      dir_d  = (shifted > 0);
      duty_d = shifted[ACC_W-1] ? DUTY_W'(-shifted) : DUTY_W'(shifted);
    end
  end

  assign ready6 = !v6_q || !out_stall_i;
  assign ready5 = !v5_q || ready6;
  assign ready4 = !v4_q || ready5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (ready4) begin
        v4_q <= valid_i;
      end
      if (ready5) begin
        v5_q <= v4_q;
      end
      if (ready6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready4 && valid_i) begin
      pp_q   <= pp_d;
      pd_q   <= pd_d;
      pi_q   <= pi_d;
      rep4_q <= res_i.report;
    end
    if (ready5 && v4_q) begin
      acc_q  <= acc_d;
      rep5_q <= rep4_q;
    end
    if (ready6 && v5_q) begin
      dir_q  <= dir_d;
      duty_q <= duty_d;
      rep6_q <= rep5_q;
    end
  end

  assign ready_o           = ready4;
  assign out_valid_o       = v6_q;
  assign direction_o       = dir_q;
  assign duty_o            = duty_q;
  assign position_report_o = rep6_q;

endmodule

@@ src/pid_motor_drive_with_encoder_count.sv @@
// Top level of the PID position controller with quadrature encoder count.
//
//   channel   handshake                 payload
//   input     in_valid_i / in_stall_o   operation_i, a_level_i, b_level_i
//   output    out_valid_o / out_stall_i direction_o, duty_o, position_report_o
//   config    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item is accepted per cycle while the input is not stalled. An encoder
// item updates the count at the edge that accepts it and gives no result. A
// control tick passes six registers: input, error, error-sum update, multiply,
// product sum, shift and clamp; its result is offered from the last of them.
// Reset clears the count, error state and pipeline and loads the default
// gains. Stalls ripple back only as far as the first empty stage, so the input
// stalls only when every stage is full.
module pid_motor_drive_with_encoder_count #(
  parameter int POSITION_WIDTH     = pidmd_pkg::POSITION_WIDTH_DEF,
  parameter int GAIN_FRACTION_BITS = pidmd_pkg::GAIN_FRACTION_BITS_DEF,
  parameter int COUNTS_PER_REV     = pidmd_pkg::COUNTS_PER_REV_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic                               a_level_i,
  input  logic                               b_level_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               direction_o,
  output logic [pidmd_pkg::DUTY_W-1:0]       duty_o,
  output logic [pidmd_pkg::REPORT_W-1:0]     position_report_o,
  input  logic                               cfg_we_i,
  input  logic [pidmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pidmd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pidmd_pkg::*;

  localparam int QW    = POSITION_WIDTH + 8;
  localparam int EXT_W = (POSITION_WIDTH > REPORT_W) ? POSITION_WIDTH : REPORT_W;

  logic signed [SETPOINT_W-1:0] setpoint_q;
  gains_t                       gains_q;

  logic                         in_accept, tick_accept, step_en;
  logic [POSITION_WIDTH-1:0]    position;
  logic [EXT_W-1:0]             pos_ext;
  logic signed [QW-1:0]         degrees;
  logic                         v1_q, s1_ready, ep_ready;
  logic signed [QW-1:0]         deg1_q;
  logic [REPORT_W-1:0]          rep1_q;
  logic                         ep_valid, dc_ready;
  err_stage_t                   ep_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      gains_q.kp <= PROP_GAIN_RESET;
      gains_q.ki <= '0;
      gains_q.kd <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SETPOINT:   setpoint_q <= cfg_data_i[SETPOINT_W-1:0];
        REG_PROP_GAIN:  gains_q.kp <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN: gains_q.ki <= cfg_data_i[GAIN_W-1:0];
        REG_DERIV_GAIN: gains_q.kd <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_ready    = !v1_q || ep_ready;
  assign in_stall_o  = !s1_ready;
  assign in_accept   = in_valid_i && s1_ready;
  assign tick_accept = in_accept && (operation_i == OP_TICK);
  assign step_en     = in_accept && (operation_i == OP_ENCODER);

  pidmd_pos_track #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .COUNTS_PER_REV(COUNTS_PER_REV)
  ) u_pos_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (step_en),
    .step_up_i  (a_level_i != b_level_i),
    .position_o (position),
    .degrees_o  (degrees)
  );

  // Narrow positions are reported zero-extended, wide ones by their low bits.
  assign pos_ext = EXT_W'(position);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s1_ready) begin
      v1_q <= tick_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_accept) begin
      deg1_q <= degrees;
      rep1_q <= pos_ext[REPORT_W-1:0];
    end
  end

  pidmd_err_path #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_err_path (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v1_q),
    .ready_o    (ep_ready),
    .degrees_i  (deg1_q),
    .report_i   (rep1_q),
    .setpoint_i (setpoint_q),
    .valid_o    (ep_valid),
    .ready_i    (dc_ready),
    .res_o      (ep_res)
  );

  pidmd_drive_calc #(
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_drive_calc (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (ep_valid),
    .ready_o           (dc_ready),
    .res_i             (ep_res),
    .gains_i           (gains_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .direction_o       (direction_o),
    .duty_o            (duty_o),
    .position_report_o (position_report_o)
  );

endmodule
